// ===== rtl/dncd_pkg.sv =====
// ----------------------------------------------------------------------------
// Day number to calendar date: shared definitions
// Calendar constants, the width rule of the constant dividers and the
// sideband records that travel beside each divider stage.
// ----------------------------------------------------------------------------
`default_nettype none

package dncd_pkg;

  localparam int unsigned DayWidth      = 32;
  localparam int unsigned SecWidth      = 17;
  localparam int unsigned ShiftedWidth  = 33;
  localparam int unsigned YearWidth     = 25;
  localparam int unsigned YearOutWidth  = 24;

  localparam int unsigned DaysPeriod    = 146097;
  localparam int unsigned DaysCentury   = 36524;
  localparam int unsigned DaysOlympiad  = 1461;
  localparam int unsigned DaysYear      = 365;
  localparam int unsigned DaysMarToDec  = 306;
  localparam int unsigned DaysWeek      = 7;
  localparam int unsigned WeekOffset    = 3;
  localparam int unsigned MarchYearDay  = 59;
  localparam int unsigned OriginBias    = 678881;
  localparam int unsigned PeriodBias    = 14700;
  localparam int unsigned SecsDay       = 86400;
  localparam int unsigned SecsMinute    = 60;
  localparam int unsigned MinsHour      = 60;
  localparam int unsigned HoursDay      = 24;
  localparam int unsigned LeapSecond    = 60;
  localparam int unsigned YearsPeriod   = 400;
  localparam int unsigned YearsCentury  = 100;
  localparam int unsigned YearsOlympiad = 4;
  localparam int unsigned YearBase      = 1900;
  localparam int unsigned DayScale      = 10;
  localparam int unsigned DayRound      = 5;
  localparam int unsigned MonthWrap     = 10;
  localparam int unsigned MonthMarch    = 2;
  localparam int unsigned MonthsYear    = 12;
  localparam int unsigned MaxMonthDay   = 31;

  localparam longint unsigned ShiftedBias =
      longint'(OriginBias) + longint'(PeriodBias) * longint'(DaysPeriod);

  function automatic int unsigned div_quot_width(int unsigned num_width,
                                                 int unsigned divisor);
    return num_width - $clog2(divisor) + 1;
  endfunction

  typedef struct packed {
    logic [SecWidth-1:0] sec;
    logic                leap;
  } tod_t;

  typedef struct packed {
    logic signed [15:0] cycles;
    logic [1:0]         century;
    logic [15:0]        day;
    tod_t               tod;
  } era_side_t;

  typedef struct packed {
    logic signed [YearWidth-1:0] year;
    logic [1:0]                  century;
    logic [2:0]                  weekday;
    tod_t                        tod;
  } cen_side_t;

  typedef struct packed {
    logic signed [YearWidth-1:0] year;
    logic                        last_day;
    logic                        bonus;
    logic [2:0]                  weekday;
    tod_t                        tod;
  } yr_side_t;

  typedef struct packed {
    logic signed [YearWidth-1:0] year;
    logic [8:0]                  yday;
    logic [2:0]                  weekday;
    tod_t                        tod;
  } mon_side_t;

  typedef struct packed {
    logic signed [YearWidth-1:0] year;
    logic [3:0]                  month;
    logic [8:0]                  yday;
    logic [2:0]                  weekday;
    tod_t                        tod;
  } mday_side_t;

  typedef struct packed {
    logic [YearOutWidth-1:0] year_out;
    logic [4:0]              mday;
    logic [3:0]              month;
    logic [8:0]              yday;
    logic [2:0]              weekday;
    logic                    leap;
  } sec_side_t;

  typedef struct packed {
    logic [5:0]              second;
    logic [YearOutWidth-1:0] year_out;
    logic [4:0]              mday;
    logic [3:0]              month;
    logic [8:0]              yday;
    logic [2:0]              weekday;
  } min_side_t;

endpackage

`default_nettype wire

// ===== rtl/day_number_to_calendar_date.sv =====
// ----------------------------------------------------------------------------
// Day number to calendar date
// Converts a Modified Julian Day number and a second of that day into the
// broken-down proleptic Gregorian date and time of day.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one beat per timestamp (day_number_i,
// second_of_day_i) under in_valid_i / in_ready_o. The output channel gives
// one beat per timestamp with the date and time fields under out_valid_o /
// out_ready_i, in input order.
// The datapath is a front register followed by eight constant dividers of
// three stages each; a beat passes the front register and then every divider
// stage in order. One beat is accepted per cycle for as long as the
// receiver takes results; the depth of the chain sets the latency.
// Every stage holds its own valid bit. When the receiver stalls, the
// stalled stages hold their beats and empty stages upstream keep filling,
// so input beats are still accepted until the whole chain is full.
// Reset clears all valid bits; no beat is in flight after reset.
// Second 86400 is reported as second 60 of 23:59. Years before 1 are
// moved down by one, as there is no year 0.
// ----------------------------------------------------------------------------
`default_nettype none

module day_number_to_calendar_date
  import dncd_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [DayWidth-1:0]     day_number_i,
  input  wire logic [SecWidth-1:0]     second_of_day_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [5:0]                   second_o,
  output logic [5:0]                   minute_o,
  output logic [4:0]                   hour_o,
  output logic [4:0]                   month_day_o,
  output logic [3:0]                   month_o,
  output logic [YearOutWidth-1:0]      year_since_1900_o,
  output logic [2:0]                   weekday_o,
  output logic [8:0]                   year_day_o
);

  localparam int unsigned U1Num  = ShiftedWidth;
  localparam int unsigned U1Quot = div_quot_width(U1Num, DaysPeriod);
  localparam int unsigned U1Rem  = $clog2(DaysPeriod);
  localparam int unsigned U2Num  = 18;
  localparam int unsigned U2Rem  = $clog2(DaysWeek);
  localparam int unsigned U3Num  = 16;
  localparam int unsigned U3Quot = div_quot_width(U3Num, DaysOlympiad);
  localparam int unsigned U3Rem  = $clog2(DaysOlympiad);
  localparam int unsigned U4Num  = 11;
  localparam int unsigned U4Quot = div_quot_width(U4Num, DaysYear);
  localparam int unsigned U4Rem  = $clog2(DaysYear);
  localparam int unsigned U5Num  = 12;
  localparam int unsigned U5Quot = div_quot_width(U5Num, DaysMarToDec);
  localparam int unsigned U5Rem  = $clog2(DaysMarToDec);
  localparam int unsigned U6Num  = 9;
  localparam int unsigned U6Quot = div_quot_width(U6Num, DayScale);
  localparam int unsigned U7Num  = SecWidth;
  localparam int unsigned U7Quot = div_quot_width(U7Num, SecsMinute);
  localparam int unsigned U7Rem  = $clog2(SecsMinute);
  localparam int unsigned U8Num  = U7Quot;
  localparam int unsigned U8Quot = div_quot_width(U8Num, MinsHour);
  localparam int unsigned U8Rem  = $clog2(MinsHour);

  // Front register.
  logic                    front_vld_q, front_vld_d, front_en;
  logic [ShiftedWidth-1:0] shifted_q, shifted_d;
  tod_t                    tod_q, tod_d;
  logic                    sec_over, leap;
  logic [SecWidth-1:0]     sec_wrap;

  logic u1_ready, u2_ready, u3_ready, u4_ready, u5_ready, u6_ready;
  logic u7_ready, u8_ready;
  logic u1_valid, u2_valid, u3_valid, u4_valid, u5_valid, u6_valid;
  logic u7_valid;

  logic [U1Quot-1:0] u1_quot;
  logic [U1Rem-1:0]  u1_rem;
  tod_t              u1_side;
  logic [U2Num-1:0]  u2_num;
  era_side_t         u2_in, u2_side;
  logic [U2Rem-1:0]  u2_rem;
  logic [U3Num-1:0]  u3_num;
  cen_side_t         u3_in, u3_side;
  logic [U3Quot-1:0] u3_quot;
  logic [U3Rem-1:0]  u3_rem;
  logic [U4Num-1:0]  u4_num;
  yr_side_t          u4_in, u4_side;
  logic [U4Quot-1:0] u4_quot;
  logic [U4Rem-1:0]  u4_rem;
  logic [U5Num-1:0]  u5_num;
  mon_side_t         u5_in, u5_side;
  logic [U5Quot-1:0] u5_quot;
  logic [U5Rem-1:0]  u5_rem;
  logic [U6Num-1:0]  u6_num;
  mday_side_t        u6_in, u6_side;
  logic [U6Quot-1:0] u6_quot;
  logic [U7Num-1:0]  u7_num;
  sec_side_t         u7_in, u7_side;
  logic [U7Quot-1:0] u7_quot;
  logic [U7Rem-1:0]  u7_rem;
  logic [U8Num-1:0]  u8_num;
  min_side_t         u8_in, u8_side;
  logic [U8Quot-1:0] u8_quot;
  logic [U8Rem-1:0]  u8_rem;

  logic [1:0]                  year_in_cycle;
  logic [8:0]                  day_in_year;
  logic                        month_wrap;
  logic signed [YearWidth-1:0] year_adj;

  // A second count past the end of the day rolls into the next day.
  always_comb begin
    sec_over    = second_of_day_i > SecWidth'(SecsDay);
    sec_wrap    = sec_over ? second_of_day_i - SecWidth'(SecsDay) : second_of_day_i;
    leap        = sec_wrap == SecWidth'(SecsDay);
    tod_d.sec   = sec_wrap - SecWidth'(leap);
    tod_d.leap  = leap;
    shifted_d   = ShiftedWidth'(34'($signed(day_number_i)) + 34'(ShiftedBias)
                                + 34'(sec_over));
  end

  assign front_en    = !front_vld_q || u1_ready;
  assign front_vld_d = front_en ? in_valid_i : front_vld_q;
  assign in_ready_o  = front_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_vld_q <= 1'b0;
    end else begin
      front_vld_q <= front_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (front_en) begin
      shifted_q <= shifted_d;
      tod_q     <= tod_d;
    end
  end

  dncd_cdiv #(
    .NumWidth (U1Num),
    .Divisor  (DaysPeriod),
    .SideWidth($bits(tod_t))
  ) u_div_period (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(front_vld_q),
    .ready_o(u1_ready),
    .num_i  (shifted_q),
    .side_i (tod_q),
    .valid_o(u1_valid),
    .ready_i(u2_ready),
    .quot_o (u1_quot),
    .rem_o  (u1_rem),
    .side_o (u1_side)
  );

  // Split the 400-year period into centuries; its last day closes century 3.
  always_comb begin
    u2_in.tod    = u1_side;
    u2_in.cycles = $signed(16'(u1_quot) - 16'(PeriodBias));
    if (u1_rem == U1Rem'(DaysPeriod - 1)) begin
      u2_in.century = 2'd3;
      u2_in.day     = 16'(DaysCentury);
    end else if (u1_rem >= U1Rem'(3 * DaysCentury)) begin
      u2_in.century = 2'd3;
      u2_in.day     = 16'(u1_rem - U1Rem'(3 * DaysCentury));
    end else if (u1_rem >= U1Rem'(2 * DaysCentury)) begin
      u2_in.century = 2'd2;
      u2_in.day     = 16'(u1_rem - U1Rem'(2 * DaysCentury));
    end else if (u1_rem >= U1Rem'(DaysCentury)) begin
      u2_in.century = 2'd1;
      u2_in.day     = 16'(u1_rem - U1Rem'(DaysCentury));
    end else begin
      u2_in.century = 2'd0;
      u2_in.day     = 16'(u1_rem);
    end
    u2_num = U2Num'(u1_rem) + U2Num'(WeekOffset);
  end

  dncd_cdiv #(
    .NumWidth (U2Num),
    .Divisor  (DaysWeek),
    .SideWidth($bits(era_side_t))
  ) u_div_week (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(u1_valid),
    .ready_o(u2_ready),
    .num_i  (u2_num),
    .side_i (u2_in),
    .valid_o(u2_valid),
    .ready_i(u3_ready),
    .quot_o (),
    .rem_o  (u2_rem),
    .side_o (u2_side)
  );

  always_comb begin
    u3_in.tod     = u2_side.tod;
    u3_in.century = u2_side.century;
    u3_in.weekday = u2_rem;
    u3_in.year    = YearWidth'(u2_side.cycles) * YearWidth'(YearsPeriod)
                  + YearWidth'(u2_side.century) * YearWidth'(YearsCentury);
    u3_num        = u2_side.day;
  end

  dncd_cdiv #(
    .NumWidth (U3Num),
    .Divisor  (DaysOlympiad),
    .SideWidth($bits(cen_side_t))
  ) u_div_olympiad (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(u2_valid),
    .ready_o(u3_ready),
    .num_i  (u3_num),
    .side_i (u3_in),
    .valid_o(u3_valid),
    .ready_i(u4_ready),
    .quot_o (u3_quot),
    .rem_o  (u3_rem),
    .side_o (u3_side)
  );

  // March to December of a cycle's first year follows 29 February only when
  // that year is a true leap year.
  always_comb begin
    u4_in.tod      = u3_side.tod;
    u4_in.weekday  = u3_side.weekday;
    u4_in.year     = u3_side.year + YearWidth'(u3_quot) * YearWidth'(YearsOlympiad);
    u4_in.last_day = u3_rem == U3Rem'(DaysOlympiad - 1);
    u4_in.bonus    = (u3_rem < U3Rem'(DaysMarToDec))
                   && (u3_quot != '0 || u3_side.century == 2'd0);
    u4_num         = U4Num'(u3_rem);
  end

  dncd_cdiv #(
    .NumWidth (U4Num),
    .Divisor  (DaysYear),
    .SideWidth($bits(yr_side_t))
  ) u_div_year (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(u3_valid),
    .ready_o(u4_ready),
    .num_i  (u4_num),
    .side_i (u4_in),
    .valid_o(u4_valid),
    .ready_i(u5_ready),
    .quot_o (u4_quot),
    .rem_o  (u4_rem),
    .side_o (u4_side)
  );

  always_comb begin
    year_in_cycle = u4_side.last_day ? 2'd3 : u4_quot[1:0];
    day_in_year   = u4_side.last_day ? 9'(DaysYear) : 9'(u4_rem);
    u5_in.tod     = u4_side.tod;
    u5_in.weekday = u4_side.weekday;
    u5_in.year    = u4_side.year + YearWidth'(year_in_cycle);
    u5_in.yday    = day_in_year + 9'(u4_side.bonus);
    u5_num        = U5Num'(day_in_year) * U5Num'(DayScale) + U5Num'(DayRound);
  end

  dncd_cdiv #(
    .NumWidth (U5Num),
    .Divisor  (DaysMarToDec),
    .SideWidth($bits(mon_side_t))
  ) u_div_month (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(u4_valid),
    .ready_o(u5_ready),
    .num_i  (u5_num),
    .side_i (u5_in),
    .valid_o(u5_valid),
    .ready_i(u6_ready),
    .quot_o (u5_quot),
    .rem_o  (u5_rem),
    .side_o (u5_side)
  );

  // January and February belong to the next calendar year.
  always_comb begin
    month_wrap    = u5_quot >= U5Quot'(MonthWrap);
    u6_in.tod     = u5_side.tod;
    u6_in.weekday = u5_side.weekday;
    u6_in.year    = u5_side.year + YearWidth'(month_wrap);
    u6_in.month   = month_wrap ? 4'(u5_quot - U5Quot'(MonthWrap))
                               : 4'(u5_quot + U5Quot'(MonthMarch));
    u6_in.yday    = month_wrap ? u5_side.yday - 9'(DaysMarToDec)
                               : u5_side.yday + 9'(MarchYearDay);
    u6_num        = U6Num'(u5_rem);
  end

  dncd_cdiv #(
    .NumWidth (U6Num),
    .Divisor  (DayScale),
    .SideWidth($bits(mday_side_t))
  ) u_div_mday (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(u5_valid),
    .ready_o(u6_ready),
    .num_i  (u6_num),
    .side_i (u6_in),
    .valid_o(u6_valid),
    .ready_i(u7_ready),
    .quot_o (u6_quot),
    .rem_o  (),
    .side_o (u6_side)
  );

  // There is no year 0: the year before 1 is -1.
  always_comb begin
    year_adj       = ($signed(u6_side.year) < $signed(YearWidth'(1)))
                   ? u6_side.year - YearWidth'(1) : u6_side.year;
    u7_in.year_out = YearOutWidth'(year_adj - YearWidth'(YearBase));
    u7_in.mday     = 5'(u6_quot) + 5'd1;
    u7_in.month    = u6_side.month;
    u7_in.yday     = u6_side.yday;
    u7_in.weekday  = u6_side.weekday;
    u7_in.leap     = u6_side.tod.leap;
    u7_num         = u6_side.tod.sec;
  end

  dncd_cdiv #(
    .NumWidth (U7Num),
    .Divisor  (SecsMinute),
    .SideWidth($bits(sec_side_t))
  ) u_div_second (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(u6_valid),
    .ready_o(u7_ready),
    .num_i  (u7_num),
    .side_i (u7_in),
    .valid_o(u7_valid),
    .ready_i(u8_ready),
    .quot_o (u7_quot),
    .rem_o  (u7_rem),
    .side_o (u7_side)
  );

  always_comb begin
    u8_in.second   = 6'(u7_rem) + 6'(u7_side.leap);
    u8_in.year_out = u7_side.year_out;
    u8_in.mday     = u7_side.mday;
    u8_in.month    = u7_side.month;
    u8_in.yday     = u7_side.yday;
    u8_in.weekday  = u7_side.weekday;
    u8_num         = u7_quot;
  end

  dncd_cdiv #(
    .NumWidth (U8Num),
    .Divisor  (MinsHour),
    .SideWidth($bits(min_side_t))
  ) u_div_minute (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(u7_valid),
    .ready_o(u8_ready),
    .num_i  (u8_num),
    .side_i (u8_in),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .quot_o (u8_quot),
    .rem_o  (u8_rem),
    .side_o (u8_side)
  );

  assign second_o          = u8_side.second;
  assign minute_o          = 6'(u8_rem);
  assign hour_o            = u8_quot[4:0];
  assign month_day_o       = u8_side.mday;
  assign month_o           = u8_side.month;
  assign year_since_1900_o = u8_side.year_out;
  assign weekday_o         = u8_side.weekday;
  assign year_day_o        = u8_side.yday;

endmodule

`default_nettype wire

// ===== rtl/dncd_cdiv.sv =====
// ----------------------------------------------------------------------------
// Constant divider stage
// Three-stage elastic pipeline that divides an unsigned value by a fixed
// divisor through a split reciprocal multiply, and carries a sideband along.
// ----------------------------------------------------------------------------
`default_nettype none

module dncd_cdiv
  import dncd_pkg::*;
#(
  parameter int unsigned NumWidth  = ShiftedWidth,
  parameter int unsigned Divisor   = DaysPeriod,
  parameter int unsigned SideWidth = $bits(tod_t),
  localparam int unsigned QuotWidth = div_quot_width(NumWidth, Divisor),
  localparam int unsigned RemWidth  = $clog2(Divisor)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire logic [NumWidth-1:0]  num_i,
  input  wire logic [SideWidth-1:0] side_i,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output logic [QuotWidth-1:0]      quot_o,
  output logic [RemWidth-1:0]       rem_o,
  output logic [SideWidth-1:0]      side_o
);

  localparam int unsigned Shift     = NumWidth + RemWidth;
  localparam int unsigned MulWidth  = NumWidth + 2;
  localparam int unsigned LoWidth   = (MulWidth + 1) / 2;
  localparam int unsigned HiWidth   = MulWidth - LoWidth;
  localparam int unsigned ProdWidth = NumWidth + MulWidth;
  localparam int unsigned PpLoWidth = NumWidth + LoWidth;
  localparam int unsigned PpHiWidth = NumWidth + HiWidth;

  localparam logic [MulWidth-1:0] Recip = MulWidth'(
      ((64'd1 << Shift) + 64'(Divisor) - 64'd1) / 64'(Divisor));
  localparam logic [LoWidth-1:0] RecipLo = Recip[LoWidth-1:0];
  localparam logic [HiWidth-1:0] RecipHi = Recip[MulWidth-1:LoWidth];

  logic [2:0] vld_q, vld_d;
  logic [2:0] en;

  logic [NumWidth-1:0]  num1_q, num2_q;
  logic [SideWidth-1:0] side1_q, side2_q, side3_q;
  logic [PpLoWidth-1:0] pplo_q, pplo_d;
  logic [PpHiWidth-1:0] pphi_q, pphi_d;
  logic [ProdWidth-1:0] prod;
  logic [QuotWidth-1:0] quot2_q, quot2_d, quot3_q;
  logic [NumWidth-1:0]  back;
  logic [RemWidth-1:0]  rem3_q, rem3_d;

  assign en[2]   = !vld_q[2] || ready_i;
  assign en[1]   = !vld_q[1] || en[2];
  assign en[0]   = !vld_q[0] || en[1];
  assign ready_o = en[0];

  always_comb begin
    vld_d[0] = en[0] ? valid_i  : vld_q[0];
    vld_d[1] = en[1] ? vld_q[0] : vld_q[1];
    vld_d[2] = en[2] ? vld_q[1] : vld_q[2];
  end

  assign pplo_d  = PpLoWidth'(num_i) * PpLoWidth'(RecipLo);
  assign pphi_d  = PpHiWidth'(num_i) * PpHiWidth'(RecipHi);
  assign prod    = (ProdWidth'(pphi_q) << LoWidth) + ProdWidth'(pplo_q);
  assign quot2_d = prod[Shift +: QuotWidth];
  assign back    = NumWidth'(quot2_q) * NumWidth'(Divisor);
  assign rem3_d  = RemWidth'(num2_q - back);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      num1_q  <= num_i;
      side1_q <= side_i;
      pplo_q  <= pplo_d;
      pphi_q  <= pphi_d;
    end
    if (en[1]) begin
      num2_q  <= num1_q;
      side2_q <= side1_q;
      quot2_q <= quot2_d;
    end
    if (en[2]) begin
      side3_q <= side2_q;
      quot3_q <= quot2_q;
      rem3_q  <= rem3_d;
    end
  end

  assign valid_o = vld_q[2];
  assign quot_o  = quot3_q;
  assign rem_o   = rem3_q;
  assign side_o  = side3_q;

endmodule

`default_nettype wire

// ===== rtl/dncd_checker.sv =====
// ----------------------------------------------------------------------------
// Day number to calendar date: port checker
// Watches the result channel of the converter and checks the hold rule and
// the ranges and consistency of the date and time fields.
// ----------------------------------------------------------------------------
`default_nettype none

module dncd_checker
  import dncd_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    out_valid_o,
  input wire logic                    out_ready_i,
  input wire logic [5:0]              second_o,
  input wire logic [5:0]              minute_o,
  input wire logic [4:0]              hour_o,
  input wire logic [4:0]              month_day_o,
  input wire logic [3:0]              month_o,
  input wire logic [YearOutWidth-1:0] year_since_1900_o,
  input wire logic [2:0]              weekday_o,
  input wire logic [8:0]              year_day_o
);

  // A stalled result beat stays on the port with its year, year day, second and hour unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(year_since_1900_o)
      && $stable(year_day_o) && $stable(second_o) && $stable(hour_o))
    else $error("result beat changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> second_o <= 6'(LeapSecond) && minute_o < 6'(MinsHour)
      && hour_o < 5'(HoursDay))
    else $error("time of day out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> month_o < 4'(MonthsYear) && month_day_o != 5'd0
      && weekday_o < 3'(DaysWeek) && year_day_o <= 9'(DaysYear))
    else $error("date field out of range");

  // A leap second is only ever the last second of the day.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && second_o == 6'(LeapSecond) |->
      minute_o == 6'(MinsHour - 1) && hour_o == 5'(HoursDay - 1))
    else $error("leap second outside 23:59");

endmodule

bind day_number_to_calendar_date dncd_checker u_dncd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .second_o         (second_o),
  .minute_o         (minute_o),
  .hour_o           (hour_o),
  .month_day_o      (month_day_o),
  .month_o          (month_o),
  .year_since_1900_o(year_since_1900_o),
  .weekday_o        (weekday_o),
  .year_day_o       (year_day_o)
);

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Day number to calendar date: testbench
// Sends Modified Julian Day timestamps through the converter and compares
// every result beat, field by field, with a calendar computed here in
// plain integer arithmetic. Directed calendar corners come first, then
// random timestamps under two patterns of sender and receiver stalls and one with none.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import dncd_pkg::*;

  localparam longint PeriodDays   = longint'(DaysPeriod);
  localparam longint CenturyDays  = longint'(DaysCentury);
  localparam longint OlympiadDays = longint'(DaysOlympiad);
  localparam longint YearDays     = longint'(DaysYear);
  localparam longint MarDecDays   = longint'(DaysMarToDec);
  localparam longint Bias         = longint'(OriginBias);
  localparam longint DaySecs      = longint'(SecsDay);
  localparam int     FlushCycles  = 40;

  typedef struct packed {
    logic [5:0]              second;
    logic [5:0]              minute;
    logic [4:0]              hour;
    logic [4:0]              month_day;
    logic [3:0]              month;
    logic [YearOutWidth-1:0] year;
    logic [2:0]              weekday;
    logic [8:0]              year_day;
  } date_t;

  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic                    in_valid_i      = 1'b0;
  logic                    in_ready_o;
  logic [DayWidth-1:0]     day_number_i    = '0;
  logic [SecWidth-1:0]     second_of_day_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i     = 1'b0;
  logic [5:0]              second_o;
  logic [5:0]              minute_o;
  logic [4:0]              hour_o;
  logic [4:0]              month_day_o;
  logic [3:0]              month_o;
  logic [YearOutWidth-1:0] year_since_1900_o;
  logic [2:0]              weekday_o;
  logic [8:0]              year_day_o;

  date_t pending_dates[$];
  date_t want_date;
  int    send_idle_pct = 15;
  int    recv_idle_pct = 51;
  int    error_count   = 0;
  int    stamps_sent   = 0;
  int    dates_checked = 0;
  int    leap_seconds  = 0;
  int    spilled_secs  = 0;
  int    early_dates   = 0;

  day_number_to_calendar_date u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .day_number_i     (day_number_i),
    .second_of_day_i  (second_of_day_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .second_o         (second_o),
    .minute_o         (minute_o),
    .hour_o           (hour_o),
    .month_day_o      (month_day_o),
    .month_o          (month_o),
    .year_since_1900_o(year_since_1900_o),
    .weekday_o        (weekday_o),
    .year_day_o       (year_day_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic date_t gregorian_of(logic [DayWidth-1:0] day_number,
                                         logic [SecWidth-1:0] second_of_day);
    longint mjd, secs, leap, total, year, day, yday, month, century, olymp;
    date_t  d;
    mjd  = longint'(signed'(day_number));
    secs = longint'(second_of_day);
    if (secs > DaySecs) begin
      secs = secs - DaySecs;
      mjd  = mjd + 1;
    end
    leap = (secs == DaySecs) ? 1 : 0;
    secs = secs - leap;

    total = mjd + Bias;
    year  = total / PeriodDays;
    day   = total % PeriodDays;
    if (day < 0) begin
      day  = day + PeriodDays;
      year = year - 1;
    end
    d.weekday = 3'((day + longint'(WeekOffset)) % longint'(DaysWeek));

    year = year * 4;
    if (day == PeriodDays - 1) begin
      century = 3;
      day     = CenturyDays;
    end else begin
      century = day / CenturyDays;
      day     = day % CenturyDays;
    end
    year  = (year + century) * 25;
    olymp = day / OlympiadDays;
    year  = (year + olymp) * 4;
    day   = day % OlympiadDays;

    yday = (day < MarDecDays && (olymp != 0 || century == 0)) ? 1 : 0;
    if (day == OlympiadDays - 1) begin
      year = year + 3;
      day  = YearDays;
    end else begin
      year = year + day / YearDays;
      day  = day % YearDays;
    end
    yday = yday + day;

    day   = day * 10 + 5;
    month = day / MarDecDays;
    day   = (day % MarDecDays) / 10;
    if (month >= 10) begin
      month = month - 10;
      yday  = yday - MarDecDays;
      year  = year + 1;
    end else begin
      month = month + 2;
      yday  = yday + longint'(MarchYearDay);
    end
    if (year < 1) begin
      year = year - 1;
    end

    d.second    = 6'(secs % 60 + leap);
    secs        = secs / 60;
    d.minute    = 6'(secs % 60);
    d.hour      = 5'(secs / 60);
    d.month_day = 5'(day + 1);
    d.month     = 4'(month);
    d.year      = YearOutWidth'(year - longint'(YearBase));
    d.year_day  = 9'(yday);
    return d;
  endfunction

  function automatic void check_field(string name, longint expected, longint actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected,
               actual);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: result beat with no timestamp outstanding", $time);
        error_count++;
      end else begin
        want_date = pending_dates.pop_front();
        check_field("second", longint'(want_date.second), longint'(second_o));
        check_field("minute", longint'(want_date.minute), longint'(minute_o));
        check_field("hour", longint'(want_date.hour), longint'(hour_o));
        check_field("month_day", longint'(want_date.month_day),
                    longint'(month_day_o));
        check_field("month", longint'(want_date.month), longint'(month_o));
        check_field("year_since_1900", longint'(want_date.year),
                    longint'(year_since_1900_o));
        check_field("weekday", longint'(want_date.weekday), longint'(weekday_o));
        check_field("year_day", longint'(want_date.year_day), longint'(year_day_o));
        dates_checked++;
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_stamp(input logic [DayWidth-1:0] day,
                            input logic [SecWidth-1:0] sec);
    date_t d;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i      <= 1'b1;
    day_number_i    <= day;
    second_of_day_i <= sec;
    do @(posedge clk_i); while (!in_ready_o);
    d = gregorian_of(day, sec);
    pending_dates.push_back(d);
    stamps_sent++;
    if (sec == SecWidth'(SecsDay)) leap_seconds++;
    if (sec > SecWidth'(SecsDay)) spilled_secs++;
    if ($signed(d.year) < -$signed(YearOutWidth'(YearBase))) early_dates++;
  endtask

  task automatic await_all_results();
    in_valid_i <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DayWidth-1:0] pick_day_number();
    int k, c, o, y;
    case ($urandom_range(9))
      0, 1: return $urandom;
      2, 3, 4: return 40000 + $urandom_range(0, 40000);
      5: return -678575 + int'($urandom_range(0, 1000)) - 500;
      6: begin
        k = int'($urandom_range(0, 100)) - 50;
        c = $urandom_range(0, 3);
        o = $urandom_range(0, 24);
        y = $urandom_range(0, 3);
        return -678881 + k * 146097 + c * 36524 + o * 1461 + y * 365
               + int'($urandom_range(0, 6)) - 3;
      end
      7: return int'($urandom_range(0, 6000000)) - 3000000;
      8: begin
        if ($urandom_range(1)) return 32'h7fff_ffff - $urandom_range(0, 1000);
        return 32'h8000_0000 + $urandom_range(0, 1000);
      end
      default: return 51544 + $urandom_range(0, 3 * 366);
    endcase
  endfunction

  function automatic logic [SecWidth-1:0] pick_second();
    int r;
    r = $urandom_range(99);
    if (r < 8) return SecWidth'(SecsDay);
    if (r < 11) return SecWidth'($urandom_range(SecsDay + 1, 2 ** SecWidth - 1));
    if (r < 16) return SecWidth'($urandom_range(SecsDay - 61, SecsDay - 1));
    return SecWidth'($urandom_range(0, SecsDay - 1));
  endfunction

  task automatic test_field_extremes();
    send_stamp(32'h8000_0000, 0);
    send_stamp(32'h7fff_ffff, SecWidth'(SecsDay - 1));
    send_stamp(0, 0);
    send_stamp(-1, SecWidth'(SecsDay - 1));
  endtask

  task automatic test_calendar_corners();
    send_stamp(51603, 43200);
    send_stamp(15078, 1);
    send_stamp(15079, 3600);
    send_stamp(51909, 86399);
    send_stamp(53064, 59);
    send_stamp(-678575, 0);
    send_stamp(-678576, 86399);
    for (int d = 60000; d < 60007; d++) begin
      send_stamp(d, 45296);
    end
  endtask

  task automatic test_leap_seconds();
    send_stamp(-1, SecWidth'(SecsDay));
    send_stamp(57203, SecWidth'(SecsDay));
    send_stamp(60000, SecWidth'(SecsDay + 1));
    send_stamp(32'h7fff_ffff, SecWidth'(2 ** SecWidth - 1));
    send_stamp(100, 100000);
  endtask

  task automatic test_random_stream(input int count, input int send_pct,
                                    input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_stamp(pick_day_number(), pick_second());
    await_all_results();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_field_extremes();
    test_calendar_corners();
    test_leap_seconds();
    await_all_results();
    test_random_stream(550, 15, 51);
    test_random_stream(550, 51, 15);
    test_random_stream(550, 0, 0);
    repeat (FlushCycles) @(posedge clk_i);
    if (pending_dates.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_dates.size());
      error_count++;
    end
    $display("Converted %0d timestamps and checked %0d dates: %0d leap seconds,",
             stamps_sent, dates_checked, leap_seconds);
    $display("%0d seconds past the day end, %0d dates before 1 AD, %0d mismatches.",
             spilled_secs, early_dates, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/dncd_pkg.sv
rtl/dncd_cdiv.sv
rtl/day_number_to_calendar_date.sv
rtl/dncd_checker.sv
sim/testbench.sv
